// File: hdl/ymfr_pkg.sv
package ymfr_pkg;

   // Frame start and end markers
   localparam logic [7:0] BYTE_SOH = 8'h01;
   localparam logic [7:0] BYTE_STX = 8'h02;
   localparam logic [7:0] BYTE_EOT = 8'h04;

   // CRC-16/XMODEM
   localparam logic [15:0] CRC_POLY = 16'h1021;
   localparam logic [15:0] CRC_INIT = 16'h0000;

   // Last payload index of a short (128) and a long (1024) frame
   localparam logic [9:0] SHORT_LAST = 10'd127;
   localparam logic [9:0] LONG_LAST  = 10'd1023;

   typedef enum logic [2:0] {
      PH_HUNT   = 3'd0,
      PH_SEQ    = 3'd1,
      PH_INV    = 3'd2,
      PH_DATA   = 3'd3,
      PH_CRC_HI = 3'd4,
      PH_CRC_LO = 3'd5
   } phase_type;

   typedef enum logic [1:0] {
      KIND_DATA = 2'd0,
      KIND_GOOD = 2'd1,
      KIND_BAD  = 2'd2,
      KIND_EOT  = 2'd3
   } kind_type;

   // One result word as produced by the deframer
   typedef struct packed {
      logic       emit;
      kind_type   kind;
      logic [7:0] data_byte;
      logic [9:0] byte_index;
      logic [7:0] block_number;
      logic [7:0] block_complement;
      logic       long_frame;
   } result_type;

endpackage

// File: hdl/ymodem_frame_receiver_crc16.sv
// YMODEM frame receiver with CRC-16/XMODEM check.
// Input channel (req_): one received serial byte per word on req_rx_byte,
// taken at a rising edge with req_valid high and req_stall low.
// Result channel (rsp_): payload bytes tagged with index, block number,
// complement and frame length; a good/bad CRC verdict after the last CRC
// byte; an end-of-transmission marker for EOT seen while hunting.
// Header bytes, the first CRC byte and bytes skipped while hunting give
// no result word.
// A byte accepted into the input register is processed from there into
// the result register, which drives the rsp_ ports. Throughput: one byte
// per cycle unless rsp_stall holds a waiting result; the CRC byte update
// and the phase machine both complete in the single processing stage.
// Reset (synchronous, active high) empties the input and result registers
// and returns the phase machine to hunting for a frame start.
// While rsp_stall holds a waiting result, processing stops for every byte,
// and req_stall rises as soon as a byte is held in the input register.
module ymodem_frame_receiver_crc16
   import ymfr_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_rx_byte,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [1:0] rsp_result_kind,
   output logic [7:0] rsp_data_byte,
   output logic [9:0] rsp_byte_index,
   output logic [7:0] rsp_block_number,
   output logic [7:0] rsp_block_complement,
   output logic       rsp_long_frame
);

   logic        in_valid_ff;
   logic [7:0]  in_byte_ff;
   logic        out_free;
   logic        step;
   result_type  result;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [1:0]  kind_ff;
   logic [7:0]  data_ff;
   logic [9:0]  index_ff;
   logic [7:0]  num_ff;
   logic [7:0]  inv_ff;
   logic        long_ff;

   // Result register can take a word when empty or draining
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign step      = in_valid_ff && out_free;
   assign req_stall = in_valid_ff && !out_free;

   // Hold the incoming byte
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (!req_stall) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         in_byte_ff <= req_rx_byte;
      end
   end

   ymfr_deframer u_deframer (
      .clock   (clock),
      .reset   (reset),
      .step    (step),
      .rx_byte (in_byte_ff),
      .result  (result)
   );

   // Load or drain the result register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (out_free) begin
         rsp_valid_in = step && result.emit;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (step && result.emit) begin
         kind_ff  <= result.kind;
         data_ff  <= result.data_byte;
         index_ff <= result.byte_index;
         num_ff   <= result.block_number;
         inv_ff   <= result.block_complement;
         long_ff  <= result.long_frame;
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_result_kind      = kind_ff;
   assign rsp_data_byte        = data_ff;
   assign rsp_byte_index       = index_ff;
   assign rsp_block_number     = num_ff;
   assign rsp_block_complement = inv_ff;
   assign rsp_long_frame       = long_ff;

endmodule

// File: hdl/ymfr_crc16.sv
module ymfr_crc16
   import ymfr_pkg::*;
(
   input  logic [15:0] crc_cur,
   input  logic [7:0]  data_byte,
   output logic [15:0] crc_next
);

   // Fold one byte into the CRC, MSB first
   always_comb begin
      logic [15:0] acc;
      acc = crc_cur ^ {data_byte, 8'h00};
      for (int k = 0; k < 8; k++) begin
         if (acc[15]) begin
            acc = {acc[14:0], 1'b0} ^ CRC_POLY;
         end else begin
            acc = {acc[14:0], 1'b0};
         end
      end
      crc_next = acc;
   end

endmodule

// File: hdl/ymfr_deframer.sv
module ymfr_deframer
   import ymfr_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        step,
   input  logic [7:0]  rx_byte,
   output result_type  result
);

   phase_type   phase_ff, phase_in;
   logic        long_ff, long_in;
   logic [9:0]  count_ff, count_in;
   logic [15:0] crc_ff, crc_in;
   logic [7:0]  seq_ff, seq_in;
   logic [7:0]  inv_ff, inv_in;
   logic [7:0]  crc_hi_ff, crc_hi_in;
   logic [15:0] crc_upd;
   logic        last_data;
   logic        frame_start;

   ymfr_crc16 u_crc (
      .crc_cur   (crc_ff),
      .data_byte (rx_byte),
      .crc_next  (crc_upd)
   );

   assign last_data   = long_ff ? (count_ff == LONG_LAST) : (count_ff == SHORT_LAST);
   assign frame_start = (rx_byte == BYTE_SOH) || (rx_byte == BYTE_STX);

   // Next phase
   always_comb begin
      phase_in = phase_ff;
      if (step) begin
         case (phase_ff)
            PH_SEQ:    phase_in = PH_INV;
            PH_INV:    phase_in = PH_DATA;
            PH_DATA:   phase_in = last_data ? PH_CRC_HI : PH_DATA;
            PH_CRC_HI: phase_in = PH_CRC_LO;
            PH_CRC_LO: phase_in = PH_HUNT;
            default:   phase_in = frame_start ? PH_SEQ : PH_HUNT;
         endcase
      end
   end

   // Frame context and result word
   always_comb begin
      long_in   = long_ff;
      count_in  = count_ff;
      crc_in    = crc_ff;
      seq_in    = seq_ff;
      inv_in    = inv_ff;
      crc_hi_in = crc_hi_ff;
      result    = '0;
      result.block_number     = seq_ff;
      result.block_complement = inv_ff;
      result.long_frame       = long_ff;
      case (phase_ff)
         PH_SEQ: begin
            seq_in = rx_byte;
         end
         PH_INV: begin
            inv_in = rx_byte;
         end
         PH_DATA: begin
            result.emit       = 1'b1;
            result.kind       = KIND_DATA;
            result.data_byte  = rx_byte;
            result.byte_index = count_ff;
            crc_in            = crc_upd;
            count_in          = count_ff + 10'd1;
         end
         PH_CRC_HI: begin
            crc_hi_in = rx_byte;
         end
         PH_CRC_LO: begin
            result.emit = 1'b1;
            result.kind = ({crc_hi_ff, rx_byte} == crc_ff) ? KIND_GOOD : KIND_BAD;
         end
         default: begin
            result.block_number     = '0;
            result.block_complement = '0;
            result.long_frame       = 1'b0;
            if (rx_byte == BYTE_EOT) begin
               result.emit = 1'b1;
               result.kind = KIND_EOT;
            end
            if (frame_start) begin
               long_in   = (rx_byte == BYTE_STX);
               count_in  = '0;
               crc_in    = CRC_INIT;
               seq_in    = '0;
               inv_in    = '0;
               crc_hi_in = '0;
            end
         end
      endcase
   end

   // Advance state on each processed word
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_HUNT;
         long_ff   <= 1'b0;
         count_ff  <= '0;
         crc_ff    <= CRC_INIT;
         seq_ff    <= '0;
         inv_ff    <= '0;
         crc_hi_ff <= '0;
      end else begin
         phase_ff <= phase_in;
         if (step) begin
            long_ff   <= long_in;
            count_ff  <= count_in;
            crc_ff    <= crc_in;
            seq_ff    <= seq_in;
            inv_ff    <= inv_in;
            crc_hi_ff <= crc_hi_in;
         end
      end
   end

endmodule
